>>> design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> design/gpps_pkg.sv
// Types, constants and helpers shared by the gimbal servo mixer modules.
package gpps_pkg;

   // restoring divider for the command term
   localparam int DIV_STEPS = 16;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [6:0]  CMD_SCALE       = 7'd80;
   localparam int          INTEG_LIMIT     = 16000;
   localparam int          RATE_LIMIT      = 640;
   // floor(m/125) = (m*16778)>>21 for m below 21499
   localparam logic [14:0] RECIP_125       = 15'd16778;
   localparam int          RECIP_125_SHIFT = 21;
   // floor(m/5) = (m*209716)>>20 for m below 2^18
   localparam logic [17:0] RECIP_5         = 18'd209716;
   localparam int          RECIP_5_SHIFT   = 20;
   localparam int          DRIVE_MAX       = 32767;
   localparam int          DRIVE_MIN       = -32768;

   // register reset values
   localparam logic [7:0]        P_GAIN_RST      = 8'd40;
   localparam logic [7:0]        I_GAIN_RST      = 8'd30;
   localparam logic [7:0]        D_GAIN_RST      = 8'd17;
   localparam logic [11:0]       PAN_CENTER_RST  = 12'd1500;
   localparam logic signed [5:0] PAN_SCALE_RST   = 6'sd1;
   localparam logic [11:0]       TILT_CENTER_RST = 12'd1500;
   localparam logic signed [5:0] TILT_SCALE_RST  = 6'sd1;

   typedef enum logic [2:0] {
      CSR_P_GAIN,
      CSR_I_GAIN,
      CSR_D_GAIN,
      CSR_PAN_CENTER,
      CSR_PAN_SCALE,
      CSR_TILT_CENTER,
      CSR_TILT_SCALE
   } csr_index_type;

   typedef struct packed {
      logic [7:0]        p_gain;
      logic [7:0]        i_gain;
      logic [7:0]        d_gain;
      logic [11:0]       pan_center;
      logic signed [5:0] pan_scale;
      logic [11:0]       tilt_center;
      logic signed [5:0] tilt_scale;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic div_step;
      logic calc1;
      logic calc2;
      logic calc3;
      logic calc4;
      logic calc5;
      logic finish;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_CALC1,
      ST_CALC2,
      ST_CALC3,
      ST_CALC4,
      ST_CALC5,
      ST_FINISH
   } state_type;

   // low bound tested first; with crossed limits a value below the low one
   // gives the low one, anything else the high one
   function automatic logic [11:0] clamp_servo(input logic signed [23:0] v,
                                               input logic [11:0] lo,
                                               input logic [11:0] hi);
      logic [11:0] r;
      if (v < $signed({12'b0, lo})) begin
         r = lo;
      end else if (v > $signed({12'b0, hi})) begin
         r = hi;
      end else begin
         r = v[11:0];
      end
      return r;
   endfunction

endpackage

>>> design/gpps_csr.sv
// Configuration register file of the gimbal servo mixer.
module gpps_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic [2:0]       csr_index,
   input  logic [11:0]      csr_wdata,
   output gpps_pkg::cfg_type cfg
);
   import gpps_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_P_GAIN:      cfg_in.p_gain      = csr_wdata[7:0];
            CSR_I_GAIN:      cfg_in.i_gain      = csr_wdata[7:0];
            CSR_D_GAIN:      cfg_in.d_gain      = csr_wdata[7:0];
            CSR_PAN_CENTER:  cfg_in.pan_center  = csr_wdata;
            CSR_PAN_SCALE:   cfg_in.pan_scale   = $signed(csr_wdata[5:0]);
            CSR_TILT_CENTER: cfg_in.tilt_center = csr_wdata;
            CSR_TILT_SCALE:  cfg_in.tilt_scale  = $signed(csr_wdata[5:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.p_gain      <= P_GAIN_RST;
         cfg_ff.i_gain      <= I_GAIN_RST;
         cfg_ff.d_gain      <= D_GAIN_RST;
         cfg_ff.pan_center  <= PAN_CENTER_RST;
         cfg_ff.pan_scale   <= PAN_SCALE_RST;
         cfg_ff.tilt_center <= TILT_CENTER_RST;
         cfg_ff.tilt_scale  <= TILT_SCALE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/gpps_ctrl.sv
// Sequencing state machine of the gimbal servo mixer.
module gpps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gpps_pkg::cmd_type cmd
);
   import gpps_pkg::*;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_PREP;
         ST_PREP:   state_in = ST_DIV;
         ST_DIV:    if (cnt_ff == CNT_LAST) state_in = ST_CALC1;
         ST_CALC1:  state_in = ST_CALC2;
         ST_CALC2:  state_in = ST_CALC3;
         ST_CALC3:  state_in = ST_CALC4;
         ST_CALC4:  state_in = ST_CALC5;
         ST_CALC5:  state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:   cmd.load     = req_valid;
         ST_PREP:   cmd.prep     = 1'b1;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_CALC1:  cmd.calc1    = 1'b1;
         ST_CALC2:  cmd.calc2    = 1'b1;
         ST_CALC3:  cmd.calc3    = 1'b1;
         ST_CALC4:  cmd.calc4    = 1'b1;
         ST_CALC5:  cmd.calc5    = 1'b1;
         ST_FINISH: cmd.finish   = out_free;
         default: ;
      endcase
   end

   assign cnt_in       = (state_ff == ST_DIV) ? CNT_W'(cnt_ff + 1'b1) : '0;
   assign out_valid_in = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

endmodule

>>> design/gpps_dp.sv
// Arithmetic datapath of the gimbal servo mixer: divider, PID terms, servo mix.
module gpps_dp #(
   parameter int PAN_LOW   = 1020,
   parameter int PAN_HIGH  = 2000,
   parameter int TILT_LOW  = 1020,
   parameter int TILT_HIGH = 2000
) (
   input  logic               clock,
   input  logic               reset,
   input  gpps_pkg::cmd_type  cmd,
   input  gpps_pkg::cfg_type  cfg,
   input  logic signed [9:0]  req_pan_command,
   input  logic signed [9:0]  req_tilt_command,
   input  logic signed [13:0] req_pan_rate,
   input  logic signed [15:0] req_tilt_angle,
   output logic [11:0]        rsp_pan_servo,
   output logic [11:0]        rsp_tilt_servo,
   output logic signed [15:0] rsp_pan_drive
);
   import gpps_pkg::*;

   localparam logic [11:0] PAN_LO  = 12'(PAN_LOW);
   localparam logic [11:0] PAN_HI  = 12'(PAN_HIGH);
   localparam logic [11:0] TILT_LO = 12'(TILT_LOW);
   localparam logic [11:0] TILT_HI = 12'(TILT_HIGH);

   // captured item
   logic signed [9:0]  pan_cmd_ff, tilt_cmd_ff;
   logic signed [13:0] rate_ff;
   logic signed [15:0] angle_ff;

   // divider
   logic [9:0]  cmd_mag;
   logic [15:0] num_in, quo_ff, quo_in;
   logic [7:0]  divisor_ff, divisor_in, rem_ff, rem_in;
   logic [8:0]  trial;
   logic        qbit, num_neg_ff;

   // loop state
   logic signed [14:0] integ_ff, integ_in;
   logic signed [13:0] prev_rate_ff;
   logic signed [14:0] delta_one_ff, delta_two_ff, delta;

   // products and terms
   logic signed [17:0] dsum_ff, dsum_in;
   logic signed [22:0] rp_prod_ff, rp_prod_in;
   logic signed [21:0] ta_prod_ff, ta_prod_in;
   logic signed [16:0] quot_s;
   logic signed [17:0] error;
   logic signed [18:0] isum;
   logic [20:0]        rp_mag;
   logic [34:0]        pdiv_ff, pdiv_in;
   logic signed [26:0] dprod_ff, dprod_in;
   logic signed [17:0] ta_div;
   logic signed [19:0] tsum;
   logic [11:0]        tilt_ff, tilt_in;
   logic [14:0]        integ_mag;
   logic [29:0]        iprod_ff, iprod_in;
   logic [14:0]        pq;
   logic signed [16:0] pq_s, pterm_ff, pterm_in;
   logic [7:0]         iq;
   logic signed [8:0]  iq_s;
   logic signed [17:0] iterm_prod_ff, iterm_prod_in;
   logic signed [11:0] iterm;
   logic signed [21:0] dterm;
   logic signed [23:0] drive_sum;
   logic signed [15:0] drive_ff, drive_in;
   logic signed [21:0] pprod_ff, pprod_in;
   logic signed [22:0] psum;

   // result register
   logic [11:0]        out_pan_ff, out_tilt_ff, out_pan_in;
   logic signed [15:0] out_drive_ff;

   // load: magnitude of command*80 over max(p_gain,1)
   assign cmd_mag    = req_pan_command[9] ? 10'(-req_pan_command) : 10'(req_pan_command);
   assign num_in     = 16'(cmd_mag) * 16'(CMD_SCALE);
   assign divisor_in = (cfg.p_gain == 8'd0) ? 8'd1 : cfg.p_gain;

   // one restoring step a cycle
   always_comb begin
      trial = {rem_ff, quo_ff[15]};
      if (trial >= {1'b0, divisor_ff}) begin
         rem_in = 8'(trial - {1'b0, divisor_ff});
         qbit   = 1'b1;
      end else begin
         rem_in = trial[7:0];
         qbit   = 1'b0;
      end
      quo_in = {quo_ff[14:0], qbit};
   end

   // prep: gyro history and the two input products
   assign delta      = 15'(rate_ff) - 15'(prev_rate_ff);
   assign dsum_in    = 18'(delta) + 18'(delta_one_ff) + 18'(delta_two_ff);
   assign rp_prod_in = 23'(rate_ff) * 23'($signed({1'b0, cfg.p_gain}));
   assign ta_prod_in = 22'($signed(cfg.tilt_scale)) * 22'(angle_ff);

   // calc1: integrator, P scaling product, D product, tilt servo
   assign quot_s = num_neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign error  = 18'(quot_s) - 18'(rate_ff);
   assign isum   = 19'(integ_ff) + 19'(error);

   always_comb begin
      if (rate_ff > 14'(RATE_LIMIT) || rate_ff < -14'(RATE_LIMIT)) begin
         integ_in = '0;
      end else if (isum > 19'(INTEG_LIMIT)) begin
         integ_in = 15'(INTEG_LIMIT);
      end else if (isum < -19'(INTEG_LIMIT)) begin
         integ_in = -15'(INTEG_LIMIT);
      end else begin
         integ_in = 15'(isum);
      end
   end

   // |rate*p_gain|/80 as (m>>4)/5
   assign rp_mag   = rp_prod_ff[22] ? 21'(-rp_prod_ff) : 21'(rp_prod_ff);
   assign pdiv_in  = 35'(rp_mag[20:4]) * 35'(RECIP_5);
   assign dprod_in = 27'(dsum_ff) * 27'($signed({1'b0, cfg.d_gain}));

   // /16 toward zero: bias negatives before the shift
   assign ta_div  = 18'((ta_prod_ff + (ta_prod_ff[21] ? 22'sd15 : 22'sd0)) >>> 4);
   assign tsum    = 20'($signed({1'b0, cfg.tilt_center})) + 20'(ta_div) + 20'(tilt_cmd_ff);
   assign tilt_in = clamp_servo(24'(tsum), TILT_LO, TILT_HI);

   // calc2: integrator/125 product, P term
   assign integ_mag = integ_ff[14] ? 15'(-integ_ff) : 15'(integ_ff);
   assign iprod_in  = 30'(integ_mag) * 30'(RECIP_125);
   assign pq        = 15'(pdiv_ff >> RECIP_5_SHIFT);
   assign pq_s      = rp_prod_ff[22] ? -$signed({2'b0, pq}) : $signed({2'b0, pq});
   assign pterm_in  = 17'(pan_cmd_ff) - pq_s;

   // calc3: times i_gain
   assign iq            = 8'(iprod_ff >> RECIP_125_SHIFT);
   assign iq_s          = integ_ff[14] ? -$signed({1'b0, iq}) : $signed({1'b0, iq});
   assign iterm_prod_in = 18'(iq_s) * 18'($signed({1'b0, cfg.i_gain}));

   // calc4: P + I - D, saturated
   assign iterm     = 12'(iterm_prod_ff >>> 6);
   assign dterm     = 22'(dprod_ff >>> 5);
   assign drive_sum = 24'(pterm_ff) + 24'(iterm) - 24'(dterm);

   always_comb begin
      if (drive_sum > 24'(DRIVE_MAX)) begin
         drive_in = 16'(DRIVE_MAX);
      end else if (drive_sum < 24'(DRIVE_MIN)) begin
         drive_in = 16'(DRIVE_MIN);
      end else begin
         drive_in = 16'(drive_sum);
      end
   end

   // calc5 and finish: pan servo
   assign pprod_in   = 22'($signed(cfg.pan_scale)) * 22'(drive_ff);
   assign psum       = 23'($signed({1'b0, cfg.pan_center})) + 23'(pprod_ff);
   assign out_pan_in = clamp_servo(24'(psum), PAN_LO, PAN_HI);

   // loop state, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff     <= '0;
         prev_rate_ff <= '0;
         delta_one_ff <= '0;
         delta_two_ff <= '0;
      end else begin
         if (cmd.prep) begin
            prev_rate_ff <= rate_ff;
            delta_two_ff <= delta_one_ff;
            delta_one_ff <= delta;
         end
         if (cmd.calc1) begin
            integ_ff <= integ_in;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pan_cmd_ff  <= req_pan_command;
         tilt_cmd_ff <= req_tilt_command;
         rate_ff     <= req_pan_rate;
         angle_ff    <= req_tilt_angle;
         num_neg_ff  <= req_pan_command[9];
         divisor_ff  <= divisor_in;
         quo_ff      <= num_in;
         rem_ff      <= '0;
      end
      if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.prep) begin
         dsum_ff    <= dsum_in;
         rp_prod_ff <= rp_prod_in;
         ta_prod_ff <= ta_prod_in;
      end
      if (cmd.calc1) begin
         pdiv_ff  <= pdiv_in;
         dprod_ff <= dprod_in;
         tilt_ff  <= tilt_in;
      end
      if (cmd.calc2) begin
         iprod_ff <= iprod_in;
         pterm_ff <= pterm_in;
      end
      if (cmd.calc3) begin
         iterm_prod_ff <= iterm_prod_in;
      end
      if (cmd.calc4) begin
         drive_ff <= drive_in;
      end
      if (cmd.calc5) begin
         pprod_ff <= pprod_in;
      end
      if (cmd.finish) begin
         out_pan_ff   <= out_pan_in;
         out_tilt_ff  <= tilt_ff;
         out_drive_ff <= drive_ff;
      end
   end

   assign rsp_pan_servo  = out_pan_ff;
   assign rsp_tilt_servo = out_tilt_ff;
   assign rsp_pan_drive  = out_drive_ff;

endmodule

>>> design/gimbal_pan_pid_servo_mixer_top.sv
// Top level of the gimbal pan PID and tilt servo mixer.
// A req transfer is taken only in idle; the item then runs through prep, the
//   bit-per-cycle restoring divider forming command*80/max(p_gain,1), the calc steps
//   and finish, and the next req is taken once the sequencer is back in idle.
// A finished result waits in the output register and the next req is taken meanwhile.
// Reset (synchronous, active high): integrator and gyro history to zero, registers
//   to their defaults, nothing pending.
module gimbal_pan_pid_servo_mixer_top #(
   parameter int PAN_LOW   = 1020,
   parameter int PAN_HIGH  = 2000,
   parameter int TILT_LOW  = 1020,
   parameter int TILT_HIGH = 2000
) (
   input  logic               clock,
   input  logic               reset,
   // configuration writes, to be made only while idle; the block does not enforce it
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [11:0]        csr_wdata,
   // control tick in
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [9:0]  req_pan_command,
   input  logic signed [9:0]  req_tilt_command,
   input  logic signed [13:0] req_pan_rate,
   input  logic signed [15:0] req_tilt_angle,
   // servo result out
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [11:0]        rsp_pan_servo,
   output logic [11:0]        rsp_tilt_servo,
   output logic signed [15:0] rsp_pan_drive
);
   import gpps_pkg::*;

   cfg_type cfg;
   cmd_type cmd;

   // gains, centres and scales
   gpps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: idle, prep, 16 divide steps, five calc steps, finish.
   // Finish holds until the output register is free.
   gpps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // arithmetic; every multiply is registered before the next one
   gpps_dp #(
      .PAN_LOW   (PAN_LOW),
      .PAN_HIGH  (PAN_HIGH),
      .TILT_LOW  (TILT_LOW),
      .TILT_HIGH (TILT_HIGH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg),
      .req_pan_command  (req_pan_command),
      .req_tilt_command (req_tilt_command),
      .req_pan_rate     (req_pan_rate),
      .req_tilt_angle   (req_tilt_angle),
      .rsp_pan_servo    (rsp_pan_servo),
      .rsp_tilt_servo   (rsp_tilt_servo),
      .rsp_pan_drive    (rsp_pan_drive)
   );

endmodule

>>> design/gpps_checker.sv
// Port-level assertion checker for the gimbal servo mixer, with its bind.
`include "assert_macros.svh"

module gpps_checker #(
   parameter int PAN_LOW   = 1020,
   parameter int PAN_HIGH  = 2000,
   parameter int TILT_LOW  = 1020,
   parameter int TILT_HIGH = 2000
) (
   input logic               clock,
   input logic               reset,
   input logic               csr_write,
   input logic [2:0]         csr_index,
   input logic [11:0]        csr_wdata,
   input logic               req_valid,
   input logic               req_ready,
   input logic signed [9:0]  req_pan_command,
   input logic signed [9:0]  req_tilt_command,
   input logic signed [13:0] req_pan_rate,
   input logic signed [15:0] req_tilt_angle,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [11:0]        rsp_pan_servo,
   input logic [11:0]        rsp_tilt_servo,
   input logic signed [15:0] rsp_pan_drive
);

   logic        pan_ok, tilt_ok;
   logic [39:0] rsp_word;

   // crossed limits give one of the two bounds
   assign pan_ok = (PAN_LOW > PAN_HIGH) ?
                   (rsp_pan_servo == 12'(PAN_HIGH) || rsp_pan_servo == 12'(PAN_LOW)) :
                   (rsp_pan_servo >= 12'(PAN_LOW) && rsp_pan_servo <= 12'(PAN_HIGH));
   assign tilt_ok = (TILT_LOW > TILT_HIGH) ?
                    (rsp_tilt_servo == 12'(TILT_HIGH) || rsp_tilt_servo == 12'(TILT_LOW)) :
                    (rsp_tilt_servo >= 12'(TILT_LOW) && rsp_tilt_servo <= 12'(TILT_HIGH));

   assign rsp_word = {rsp_pan_servo, rsp_tilt_servo, rsp_pan_drive};

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))
   `ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid && req_ready)
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPLY(a_pan_range, clock, reset, rsp_valid, pan_ok)
   `ASSERT_IMPLY(a_tilt_range, clock, reset, rsp_valid, tilt_ok)

endmodule

bind gimbal_pan_pid_servo_mixer_top gpps_checker #(
   .PAN_LOW   (PAN_LOW),
   .PAN_HIGH  (PAN_HIGH),
   .TILT_LOW  (TILT_LOW),
   .TILT_HIGH (TILT_HIGH)
) u_gpps_checker (.*);

>>> bench/gimbal_pan_pid_servo_mixer_top_test.sv
// Self-checking bench for the gimbal pan PID and tilt servo mixer.
`timescale 1ns / 1ps

module gimbal_pan_pid_servo_mixer_top_test;
   import gpps_pkg::*;

   // Clamp limits, kept equal to the DUT defaults and passed in explicitly.
   localparam int PAN_LOW   = 1020;
   localparam int PAN_HIGH  = 2000;
   localparam int TILT_LOW  = 1020;
   localparam int TILT_HIGH = 2000;

   // Run length: stop feeding ticks once this many have gone in.
   localparam int TICK_TARGET   = 1700;
   // Settling time after the final drain, before the verdict.
   localparam int SETTLE_CYCLES = 40;
   // Hard-stop bound, far above what the slowest legal run needs.
   localparam int CYCLE_LIMIT   = 800000;

   // One control tick, and the servo result it produces.
   typedef struct {
      logic signed [9:0]  pan_command;
      logic signed [9:0]  tilt_command;
      logic signed [13:0] pan_rate;
      logic signed [15:0] tilt_angle;
   } tick_type;

   typedef struct {
      logic [11:0]        pan_servo;
      logic [11:0]        tilt_servo;
      logic signed [15:0] pan_drive;
   } servo_type;

   // All DUT inputs start at known values.
   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               csr_write        = 1'b0;
   logic [2:0]         csr_index        = '0;
   logic [11:0]        csr_wdata        = '0;
   logic               req_valid        = 1'b0;
   logic               req_ready;
   logic signed [9:0]  req_pan_command  = '0;
   logic signed [9:0]  req_tilt_command = '0;
   logic signed [13:0] req_pan_rate     = '0;
   logic signed [15:0] req_tilt_angle   = '0;
   logic               rsp_valid;
   logic               rsp_ready        = 1'b1;
   logic [11:0]        rsp_pan_servo;
   logic [11:0]        rsp_tilt_servo;
   logic signed [15:0] rsp_pan_drive;

   // Shadow copy of the register file, tracked on every write.
   logic [7:0]         p_gain_cfg      = P_GAIN_RST;
   logic [7:0]         i_gain_cfg      = I_GAIN_RST;
   logic [7:0]         d_gain_cfg      = D_GAIN_RST;
   logic [11:0]        pan_center_cfg  = PAN_CENTER_RST;
   logic signed [5:0]  pan_scale_cfg   = PAN_SCALE_RST;
   logic [11:0]        tilt_center_cfg = TILT_CENTER_RST;
   logic signed [5:0]  tilt_scale_cfg  = TILT_SCALE_RST;

   // Controller state as the predictor sees it: integrator and gyro history.
   longint integ_acc   = 0;
   longint last_rate   = 0;
   longint delta_back1 = 0;
   longint delta_back2 = 0;

   servo_type servo_due[$];     // servo results still owed by the DUT, oldest first
   int        ticks_sent  = 0;
   int        servo_faults = 0;
   int        cycle_count = 0;
   bit        calm        = 1'b0;   // when set, no random sender gaps and no new rsp_ready stalls
   int unsigned hold_left = 0;

   gimbal_pan_pid_servo_mixer_top #(
      .PAN_LOW   (PAN_LOW),
      .PAN_HIGH  (PAN_HIGH),
      .TILT_LOW  (TILT_LOW),
      .TILT_HIGH (TILT_HIGH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pan_command  (req_pan_command),
      .req_tilt_command (req_tilt_command),
      .req_pan_rate     (req_pan_rate),
      .req_tilt_angle   (req_tilt_angle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pan_servo    (rsp_pan_servo),
      .rsp_tilt_servo   (rsp_tilt_servo),
      .rsp_pan_drive    (rsp_pan_drive)
   );

   always #5 clock = ~clock;

   // Hard stop in case the DUT hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver back-pressure: alternating open and stalled runs, mostly short,
   // now and then long enough that a finished result sits in the output
   // register while the next tick is already being worked on.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else if (rsp_ready) begin
         rsp_ready <= 1'b0;
         hold_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b1;
         hold_left <= $urandom_range(0, 12);
      end
   end

   // Result checker: every rsp transfer is matched against the oldest
   // outstanding prediction. Only the first ten faults are printed.
   always @(posedge clock) begin : rsp_check
      servo_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (servo_due.size() == 0) begin
            servo_faults++;
            if (servo_faults <= 10) begin
               $display("%0t: unexpected result pan_servo %0d tilt_servo %0d pan_drive %0d",
                        $realtime, rsp_pan_servo, rsp_tilt_servo, rsp_pan_drive);
            end
         end else begin
            want = servo_due.pop_front();
            if (rsp_pan_servo !== want.pan_servo || rsp_tilt_servo !== want.tilt_servo ||
                rsp_pan_drive !== want.pan_drive) begin
               servo_faults++;
               if (servo_faults <= 10) begin
                  $display("%0t: servo mismatch pan_servo %0d/%0d tilt_servo %0d/%0d",
                           $realtime, want.pan_servo, rsp_pan_servo,
                           want.tilt_servo, rsp_tilt_servo);
                  $display("         pan_drive %0d/%0d (expected/actual)",
                           want.pan_drive, rsp_pan_drive);
               end
            end
         end
      end
   end

   function automatic longint limit(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Predicts one tick and advances the controller state. Everything is done
   // in 64-bit signed arithmetic so nothing wraps before the final clamps;
   // '/' truncates toward zero and '>>>' floors, as the hardware must.
   function automatic servo_type mix_servo_tick(input tick_type t);
      longint cmd, rate, divisor, error, p_term, i_term, d_term;
      longint delta, delta_sum, drive, pan_sum, tilt_sum;
      servo_type r;
      cmd  = t.pan_command;
      rate = t.pan_rate;
      // a zero proportional gain divides the command term by one
      divisor = (p_gain_cfg == 0) ? 1 : longint'(p_gain_cfg);
      error   = (cmd * 80) / divisor - rate;

      integ_acc = limit(integ_acc + error, -INTEG_LIMIT, INTEG_LIMIT);
      if (rate > RATE_LIMIT || rate < -RATE_LIMIT) integ_acc = 0;
      i_term = ((integ_acc / 125) * longint'(i_gain_cfg)) >>> 6;

      p_term = cmd - (rate * longint'(p_gain_cfg)) / 80;

      delta       = rate - last_rate;
      last_rate   = rate;
      delta_sum   = delta + delta_back1 + delta_back2;
      delta_back2 = delta_back1;
      delta_back1 = delta;
      d_term      = (delta_sum * longint'(d_gain_cfg)) >>> 5;

      // saturated drive also feeds the pan servo
      drive    = limit(p_term + i_term - d_term, DRIVE_MIN, DRIVE_MAX);
      pan_sum  = limit(longint'(pan_center_cfg) + longint'(pan_scale_cfg) * drive,
                       PAN_LOW, PAN_HIGH);
      tilt_sum = limit(longint'(tilt_center_cfg) +
                       (longint'(tilt_scale_cfg) * longint'(t.tilt_angle)) / 16 +
                       longint'(t.tilt_command), TILT_LOW, TILT_HIGH);

      r.pan_servo  = pan_sum[11:0];
      r.tilt_servo = tilt_sum[11:0];
      r.pan_drive  = drive[15:0];
      return r;
   endfunction

   function automatic tick_type make_tick(input int cmd, input int tcmd, input int rate,
                                          input int angle);
      tick_type t;
      t.pan_command  = 10'(cmd);
      t.tilt_command = 10'(tcmd);
      t.pan_rate     = 14'(rate);
      t.tilt_angle   = 16'(angle);
      return t;
   endfunction

   // One req transfer. Valid stays up with the payload steady until taken;
   // the caller lowers it with idle_sender when a gap is wanted.
   task automatic send_tick(input tick_type t);
      @(negedge clock);
      req_valid        <= 1'b1;
      req_pan_command  <= t.pan_command;
      req_tilt_command <= t.tilt_command;
      req_pan_rate     <= t.pan_rate;
      req_tilt_angle   <= t.tilt_angle;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      servo_due.push_back(mix_servo_tick(t));
      ticks_sent++;
   endtask

   task automatic idle_sender(input int unsigned cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop sending and wait until every owed result has come back; the DUT is
   // idle afterwards since every tick yields exactly one result.
   task automatic drain_servo();
      idle_sender(0);
      while (servo_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [11:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_P_GAIN:      p_gain_cfg      = value[7:0];
         CSR_I_GAIN:      i_gain_cfg      = value[7:0];
         CSR_D_GAIN:      d_gain_cfg      = value[7:0];
         CSR_PAN_CENTER:  pan_center_cfg  = value[11:0];
         CSR_PAN_SCALE:   pan_scale_cfg   = value[5:0];
         CSR_TILT_CENTER: tilt_center_cfg = value[11:0];
         CSR_TILT_SCALE:  tilt_scale_cfg  = value[5:0];
         default: ;
      endcase
   endtask

   task automatic set_gains(input logic [7:0] p, input logic [7:0] i, input logic [7:0] d,
                            input logic [11:0] pc, input logic signed [5:0] ps,
                            input logic [11:0] tc, input logic signed [5:0] ts);
      write_reg(CSR_P_GAIN, {4'd0, p});
      write_reg(CSR_I_GAIN, {4'd0, i});
      write_reg(CSR_D_GAIN, {4'd0, d});
      write_reg(CSR_PAN_CENTER, pc);
      write_reg(CSR_PAN_SCALE, {6'd0, ps});
      write_reg(CSR_TILT_CENTER, tc);
      write_reg(CSR_TILT_SCALE, {6'd0, ts});
   endtask

   function automatic logic [7:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd1;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // centres mostly near mid travel so the servo clamps do not swallow everything
   function automatic logic [11:0] pick_center();
      case ($urandom_range(0, 7))
         0:       return 12'd0;
         1:       return 12'd4095;
         2, 3:    return 12'($urandom_range(0, 4095));
         default: return 12'($urandom_range(1200, 1800));
      endcase
   endfunction

   function automatic logic signed [5:0] pick_scale();
      case ($urandom_range(0, 9))
         0:          return -6'sd16;
         1:          return 6'sd16;
         2:          return 6'($urandom_range(0, 63));
         3, 4, 5, 6: return 6'(int'($urandom_range(0, 8)) - 4);
         default:    return 6'(int'($urandom_range(0, 32)) - 16);
      endcase
   endfunction

   // Reset register values: stick and tilt extremes, and the integrator
   // kept at a gyro rate of exactly 640 but cleared just beyond it.
   task automatic test_reset_defaults();
      send_tick(make_tick(0, 0, 0, 0));
      send_tick(make_tick(511, 511, 0, 32767));
      send_tick(make_tick(-512, -512, 0, -32768));
      send_tick(make_tick(300, 0, 640, 0));
      send_tick(make_tick(300, 0, 641, 0));
      send_tick(make_tick(-300, 0, -640, 0));
      send_tick(make_tick(-300, 0, -641, 0));
      send_tick(make_tick(0, 100, 8191, 1000));
      send_tick(make_tick(0, -100, -8192, -1000));
      drain_servo();
   endtask

   // Zero proportional gain: divisor taken as one, so the error is huge and
   // the integrator runs into both of its limits.
   task automatic test_zero_p_gain();
      set_gains(8'd0, 8'd255, 8'd0, 12'd4095, 6'sd16, 12'd0, -6'sd16);
      send_tick(make_tick(500, 0, 0, 0));
      send_tick(make_tick(500, 0, 0, 16));
      send_tick(make_tick(500, 0, 0, -16));
      send_tick(make_tick(-512, 0, 0, 32767));
      send_tick(make_tick(-512, 0, 0, -32768));
      drain_servo();
   endtask

   // Full-scale gyro swings with the largest derivative gain push the drive
   // past 16 bits; the saturated value then meets a negative pan scale.
   task automatic test_drive_saturation();
      set_gains(8'd255, 8'd0, 8'd255, 12'd0, -6'sd16, 12'd4095, 6'sd16);
      send_tick(make_tick(511, -512, 8191, 32767));
      send_tick(make_tick(-512, 511, -8192, -32768));
      send_tick(make_tick(511, 0, 8191, 0));
      send_tick(make_tick(-512, 0, -8192, 0));
      send_tick(make_tick(0, 0, 0, 0));
      drain_servo();
   endtask

   // Scale registers at the ends of their six-bit range.
   task automatic test_scale_extremes();
      set_gains(8'd1, 8'd128, 8'd1, 12'd2048, -6'sd32, 12'd2048, 6'sd31);
      send_tick(make_tick(5, 511, 3, 32767));
      send_tick(make_tick(-5, -512, -3, -32768));
      send_tick(make_tick(1, 0, 0, 17));
      send_tick(make_tick(-1, 0, 0, -17));
      drain_servo();
   endtask

   // Random phases: fresh register settings, then a run of ticks whose gyro
   // rate wanders slowly (so the integrator and derivative history build up)
   // with occasional full-range jumps thrown in as noise.
   task automatic test_random_phases();
      int walk, rate, cmd, angle, phase_len, burst_left;
      while (ticks_sent < TICK_TARGET) begin
         drain_servo();
         set_gains(pick_gain(), pick_gain(), pick_gain(), pick_center(), pick_scale(),
                   pick_center(), pick_scale());
         calm       = ($urandom_range(0, 3) == 0);
         phase_len  = $urandom_range(30, 150);
         walk       = int'($urandom_range(0, 1200)) - 600;
         burst_left = $urandom_range(1, 10);
         repeat (phase_len) begin
            walk = walk + int'($urandom_range(0, 120)) - 60;
            if (walk > 900) walk = 900;
            if (walk < -900) walk = -900;
            rate = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 16383)) - 8192 : walk;
            cmd  = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 100)) - 50
                                               : int'($urandom_range(0, 1023));
            angle = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 4096)) - 2048
                                                : int'($urandom_range(0, 65535));
            send_tick(make_tick(cmd, int'($urandom_range(0, 1023)), rate, angle));
            // bursts with random gaps, so pauses land on every divider step
            if (!calm) begin
               burst_left--;
               if (burst_left == 0) begin
                  idle_sender($urandom_range(1, 30));
                  burst_left = $urandom_range(1, 10);
               end
            end
            // now and then hold off until the DUT has emptied completely
            if ($urandom_range(0, 199) == 0) drain_servo();
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_p_gain();
      test_drive_saturation();
      test_scale_extremes();
      test_random_phases();

      drain_servo();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (servo_faults == 0 && servo_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
